### src/ssli_pkg.sv
// ----------------------------------------------------------------------------
// ssli_pkg
// Shared types and constants for the servo slew-limited interpolator.
// ----------------------------------------------------------------------------
package ssli_pkg;

    localparam int AXES      = 6;
    localparam int ANG_W     = 11;
    localparam int US_W      = 12;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 12;
    localparam int JOINT_MAX = 1800;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_STEP   = 3'd0,
        REG_SUBSTEPS   = 3'd1,
        REG_DEADBAND   = 3'd2,
        REG_DEG_MIN    = 3'd3,
        REG_DEG_MAX    = 3'd4,
        REG_US_AT_MIN  = 3'd5,
        REG_US_AT_MAX  = 3'd6
    } reg_idx_t;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    typedef struct packed {
        logic [ANG_W-1:0] target_base;
        logic [ANG_W-1:0] target_joint1;
        logic [ANG_W-1:0] target_joint2;
        logic [ANG_W-1:0] target_joint3;
        logic [ANG_W-1:0] target_joint4;
        logic [ANG_W-1:0] target_joint5;
    } target_t;

    typedef struct packed {
        logic [ANG_W-1:0] pose_base;
        logic [ANG_W-1:0] pose_joint1;
        logic [ANG_W-1:0] pose_joint2;
        logic [ANG_W-1:0] pose_joint3;
        logic [ANG_W-1:0] pose_joint4;
        logic [ANG_W-1:0] pose_joint5;
        logic [US_W-1:0]  base_pulse_us;
        logic             last_substep;
    } pose_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic sub_step;
        logic last;
    } lane_cmd_t;

    typedef struct packed {
        logic [ANG_W-1:0] max_step;
        logic [ANG_W-1:0] deadband;
        logic [ANG_W-1:0] deg_min;
        logic [ANG_W-1:0] deg_max;
    } lane_cfg_t;

endpackage

### src/ssli_if.sv
// ----------------------------------------------------------------------------
// ssli_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface ssli_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/servo_slew_limited_interpolator.sv
// ----------------------------------------------------------------------------
// servo_slew_limited_interpolator
// Six-axis slew-limited target follower with linear pose interpolation.
// ----------------------------------------------------------------------------
// Channels: target (sink) takes one word of six target angles; pose (source)
// gives one word per interpolated pose, last_substep set on the final one.
// cfg_we/cfg_index/cfg_data write the registers; write only while idle.
// Each target is taken only while the block is idle. Six axis lanes compute
// the limited goals in the accept cycle, then run a serial divide of each
// step by the substep count n in parallel. Each pose then passes the states
// STEP (lane update), MUL (multiply for the base pulse map), PDIV (serial
// divide by the base range span) and EMIT (output load); PDIV is the longest
// of these. A single output register holds the current pose; while the
// receiver stalls, the next pose is computed and waits for the register.
// Reset puts every axis at INIT_ANGLE with no direction and loads the
// register defaults.
// ----------------------------------------------------------------------------
module servo_slew_limited_interpolator #(
    parameter int MAX_SUBSTEPS = 64,
    parameter int SAFE_MIN_US  = 500,
    parameter int SAFE_MAX_US  = 2500,
    parameter int INIT_ANGLE   = 900
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ssli_if.sink                        target,
    ssli_if.source                      pose,
    input  logic                        cfg_we,
    input  logic [ssli_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ssli_pkg::CFG_W-1:0]  cfg_data
);
    import ssli_pkg::*;

    localparam int NW = $clog2(MAX_SUBSTEPS + 1);
    localparam int PW = 23;

    typedef enum logic [2:0] {IDLE, DIV, STEP, MUL, PDIV, EMIT} state_t;

    state_t state_reg;
    logic [4:0]        cnt_reg;
    logic [NW-1:0]     n_reg, s_reg;

    logic [ANG_W-1:0]  max_step_reg, deadband_reg, deg_min_reg, deg_max_reg;
    logic [6:0]        substeps_reg;
    logic [US_W-1:0]   us_min_reg, us_max_reg;

    logic [PW-1:0]     pnum_reg;
    logic [ANG_W-1:0]  pden_reg, prem_reg;
    logic              pneg_reg, pzero_reg;

    pose_t             out_reg;
    logic              out_valid_reg;

    lane_cmd_t         cmd;
    lane_cfg_t         lcfg;
    logic [ANG_W-1:0]  tgt [AXES];
    logic [ANG_W-1:0]  pos [AXES];

    logic              accept, last, emit;
    logic [NW-1:0]     n_calc;
    logic signed [12:0] da, dus;
    logic signed [11:0] span;
    logic signed [25:0] prod;
    logic [ANG_W:0]    prem_t;
    logic              pge;
    logic signed [25:0] qs, us, us_floor;
    logic [US_W-1:0]   us_clamped;

    assign accept       = target.valid && target.ready;
    assign target.ready = (state_reg == IDLE);
    assign pose.valid   = out_valid_reg;
    assign pose.data    = out_reg;
    assign last         = (s_reg == n_reg);
    assign emit         = (state_reg == EMIT) && (!out_valid_reg || pose.ready);

    assign tgt[0] = target.data.target_base;
    assign tgt[1] = target.data.target_joint1;
    assign tgt[2] = target.data.target_joint2;
    assign tgt[3] = target.data.target_joint3;
    assign tgt[4] = target.data.target_joint4;
    assign tgt[5] = target.data.target_joint5;

    assign lcfg = '{max_step: max_step_reg, deadband: deadband_reg,
                    deg_min: deg_min_reg, deg_max: deg_max_reg};

    always_comb
    begin
        cmd.load     = accept;
        cmd.div_step = (state_reg == DIV);
        cmd.sub_step = (state_reg == STEP);
        cmd.last     = (state_reg == STEP) && ((s_reg + NW'(1)) == n_reg);
    end

    always_comb
    begin
        if (substeps_reg == 7'd0)
            n_calc = NW'(1);
        else if (int'(substeps_reg) > MAX_SUBSTEPS)
            n_calc = NW'(MAX_SUBSTEPS);
        else
            n_calc = NW'(substeps_reg);
    end

    for (genvar i = 0; i < AXES; i++) begin : g_lane
        ssli_lane #(
            .NW         (NW),
            .INIT_ANGLE (INIT_ANGLE),
            .IS_BASE    (i == 0)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd),
            .cfg    (lcfg),
            .n      (n_reg),
            .target (tgt[i]),
            .pose   (pos[i])
        );
    end

    // base pulse map: (a - min) * (us_max - us_min) / (max - min) + us_min
    always_comb
    begin
        da     = $signed({2'b00, pos[0]}) - $signed({2'b00, deg_min_reg});
        dus    = $signed({1'b0, us_max_reg}) - $signed({1'b0, us_min_reg});
        span   = $signed({1'b0, deg_max_reg}) - $signed({1'b0, deg_min_reg});
        prod   = da * dus;
        prem_t = {prem_reg, pnum_reg[PW-1]};
        pge    = prem_t >= {1'b0, pden_reg};
        qs     = pzero_reg ? 26'sd0
               : (pneg_reg ? -$signed({3'b000, pnum_reg}) : $signed({3'b000, pnum_reg}));
        us     = $signed({14'd0, us_min_reg}) + qs;
        // floor first, then ceiling
        us_floor = (us < 26'(SAFE_MIN_US)) ? 26'(SAFE_MIN_US) : us;
        if (us_floor > 26'(SAFE_MAX_US))
            us_clamped = US_W'(SAFE_MAX_US);
        else
            us_clamped = us_floor[US_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_step_reg <= ANG_W'(50);
            substeps_reg <= 7'd8;
            deadband_reg <= ANG_W'(20);
            deg_min_reg  <= '0;
            deg_max_reg  <= ANG_W'(1800);
            us_min_reg   <= US_W'(500);
            us_max_reg   <= US_W'(2500);
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_MAX_STEP:  max_step_reg <= cfg_data[ANG_W-1:0];
                REG_SUBSTEPS:  substeps_reg <= cfg_data[6:0];
                REG_DEADBAND:  deadband_reg <= cfg_data[ANG_W-1:0];
                REG_DEG_MIN:   deg_min_reg  <= cfg_data[ANG_W-1:0];
                REG_DEG_MAX:   deg_max_reg  <= cfg_data[ANG_W-1:0];
                REG_US_AT_MIN: us_min_reg   <= cfg_data;
                REG_US_AT_MAX: us_max_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            n_reg         <= NW'(1);
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pose.valid && pose.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (accept) begin
                        n_reg     <= n_calc;
                        s_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= DIV;
                    end
                end
                DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(ANG_W - 1))
                        state_reg <= STEP;
                end
                STEP:
                begin
                    s_reg     <= s_reg + NW'(1);
                    state_reg <= MUL;
                end
                MUL:
                begin
                    pnum_reg  <= prod[25] ? PW'(-prod) : prod[PW-1:0];
                    pden_reg  <= span[11] ? ANG_W'(-span) : span[ANG_W-1:0];
                    pneg_reg  <= prod[25] ^ span[11];
                    pzero_reg <= (span == 12'sd0);
                    prem_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= PDIV;
                end
                PDIV:
                begin
                    pnum_reg <= {pnum_reg[PW-2:0], pge};
                    prem_reg <= pge ? ANG_W'(prem_t - {1'b0, pden_reg}) : prem_t[ANG_W-1:0];
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(PW - 1))
                        state_reg <= EMIT;
                end
                EMIT:
                begin
                    if (emit) begin
                        out_reg.pose_base     <= pos[0];
                        out_reg.pose_joint1   <= pos[1];
                        out_reg.pose_joint2   <= pos[2];
                        out_reg.pose_joint3   <= pos[3];
                        out_reg.pose_joint4   <= pos[4];
                        out_reg.pose_joint5   <= pos[5];
                        out_reg.base_pulse_us <= us_clamped;
                        out_reg.last_substep  <= last;
                        state_reg             <= last ? IDLE : STEP;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != IDLE) |-> (s_reg <= n_reg))
        else $error("substep counter past substep count");
    a_pulse_window: assert property (@(posedge clk) disable iff (!rst_n)
        pose.valid |-> ((SAFE_MIN_US > SAFE_MAX_US)
                        || ((int'(pose.data.base_pulse_us) >= SAFE_MIN_US)
                            && (int'(pose.data.base_pulse_us) <= SAFE_MAX_US))))
        else $error("pulse width outside safe window");
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !target.ready)
        else $error("new word taken while previous target in work");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg != '0) && (int'(n_reg) <= MAX_SUBSTEPS))
        else $error("substep count out of range");
`endif

endmodule

### src/ssli_lane.sv
// ----------------------------------------------------------------------------
// ssli_lane
// One axis: slew/deadband/clamp of the goal, serial divide of the step by
// the substep count, and incremental quotient/remainder interpolation.
// ----------------------------------------------------------------------------
module ssli_lane #(
    parameter int NW         = 7,
    parameter int INIT_ANGLE = 900,
    parameter bit IS_BASE    = 1'b0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ssli_pkg::lane_cmd_t       cmd,
    input  ssli_pkg::lane_cfg_t       cfg,
    input  logic [NW-1:0]             n,
    input  logic [ssli_pkg::ANG_W-1:0] target,
    output logic [ssli_pkg::ANG_W-1:0] pose
);
    import ssli_pkg::*;

    logic [ANG_W-1:0] cur_reg, pose_reg, num_reg, accq_reg;
    logic [ANG_W-1:0] cur_next, pose_next, num_next, accq_next;
    logic [1:0]       dir_reg, dir_next;
    logic [NW-1:0]    rem_reg, rem_next, accr_reg, accr_next;
    logic             neg_reg, neg_next;

    logic signed [12:0] delta, capped, lim, ms, v;
    logic [ANG_W-1:0]   mag, goal;
    logic signed [12:0] d;
    logic               hold;
    logic [NW:0]        rem_t, r_sum;
    logic               ge, wrap;
    logic [ANG_W-1:0]   q_step;

    function automatic logic [ANG_W-1:0] clamp_ang(input logic signed [12:0] x,
                                                   input lane_cfg_t c);
        logic [ANG_W-1:0] r;
        r = x[ANG_W-1:0];
        if (IS_BASE) begin
            if (x < $signed({2'b00, c.deg_min}))
                r = c.deg_min;
            else if (x > $signed({2'b00, c.deg_max}))
                r = c.deg_max;
        end else begin
            if (x < 13'sd0)
                r = '0;
            else if (x > 13'(JOINT_MAX))
                r = ANG_W'(JOINT_MAX);
        end
        return r;
    endfunction

    always_comb
    begin
        delta  = $signed({2'b00, target}) - $signed({2'b00, cur_reg});
        mag    = delta[12] ? ANG_W'(-delta) : delta[ANG_W-1:0];
        hold   = (dir_reg != DIR_NONE) && (delta != 13'sd0)
                 && ((delta > 13'sd0 && dir_reg != DIR_UP)
                     || (delta < 13'sd0 && dir_reg != DIR_DOWN))
                 && (mag <= cfg.deadband);
        ms     = $signed({2'b00, cfg.max_step});
        capped = delta;
        if (delta > ms)
            capped = ms;
        else if (delta < -ms)
            capped = -ms;
        lim  = $signed({2'b00, cur_reg}) + capped;
        goal = hold ? cur_reg : clamp_ang(lim, cfg);
        d    = $signed({2'b00, goal}) - $signed({2'b00, cur_reg});

        rem_t = {rem_reg, num_reg[ANG_W-1]};
        ge    = rem_t >= {1'b0, n};

        r_sum  = {1'b0, accr_reg} + {1'b0, rem_reg};
        wrap   = r_sum >= {1'b0, n};
        q_step = accq_reg + num_reg + ANG_W'(wrap);
        v      = neg_reg ? $signed({2'b00, cur_reg}) - $signed({2'b00, q_step})
                         : $signed({2'b00, cur_reg}) + $signed({2'b00, q_step});

        cur_next  = cur_reg;
        dir_next  = dir_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        accq_next = accq_reg;
        accr_next = accr_reg;
        neg_next  = neg_reg;
        pose_next = pose_reg;

        if (cmd.load) begin
            neg_next  = d[12];
            num_next  = d[12] ? ANG_W'(-d) : d[ANG_W-1:0];
            rem_next  = '0;
            accq_next = '0;
            accr_next = '0;
            if (!hold && goal != cur_reg)
                dir_next = (goal > cur_reg) ? DIR_UP : DIR_DOWN;
        end else if (cmd.div_step) begin
            num_next = {num_reg[ANG_W-2:0], ge};
            rem_next = ge ? NW'(rem_t - {1'b0, n}) : NW'(rem_t);
        end else if (cmd.sub_step) begin
            accq_next = q_step;
            accr_next = wrap ? NW'(r_sum - {1'b0, n}) : NW'(r_sum);
            pose_next = clamp_ang(v, cfg);
            if (cmd.last)
                cur_next = IS_BASE ? clamp_ang(v, cfg) : v[ANG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_reg <= ANG_W'(INIT_ANGLE);
            dir_reg <= DIR_NONE;
        end else begin
            cur_reg <= cur_next;
            dir_reg <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        accq_reg <= accq_next;
        accr_reg <= accr_next;
        neg_reg  <= neg_next;
        pose_reg <= pose_next;
    end

    assign pose = pose_reg;

endmodule

### dv/tb_servo_slew_limited_interpolator.sv
// ----------------------------------------------------------------------------
// tb_servo_slew_limited_interpolator
// Self-checking bench: directed and random target words go in on the target
// channel, an in-bench model of the slew limiter and interpolator predicts
// every pose word, and each pose word is compared field by field in order.
// Both channels idle at random; registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_servo_slew_limited_interpolator;
    import ssli_pkg::*;

    localparam int        MAX_SUB    = 64;
    localparam int        SAFE_LO    = 500;
    localparam int        SAFE_HI    = 2500;
    localparam int        HOME_ANGLE = 900;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ssli_if #(.T(target_t)) tgt ();
    ssli_if #(.T(pose_t))   pose ();

    servo_slew_limited_interpolator #(
        .MAX_SUBSTEPS (MAX_SUB),
        .SAFE_MIN_US  (SAFE_LO),
        .SAFE_MAX_US  (SAFE_HI),
        .INIT_ANGLE   (HOME_ANGLE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .target    (tgt),
        .pose      (pose),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state and register copy
    int          axis_angle [AXES];
    logic [1:0]  axis_dir   [AXES];
    logic [10:0] lim_step;
    logic [6:0]  pose_count;
    logic [10:0] rev_band;
    logic [10:0] deg_lo;
    logic [10:0] deg_hi;
    logic [11:0] us_lo;
    logic [11:0] us_hi;

    pose_t poses_due[$];
    int    fail_count;
    int    ready_hold;
    bit    ready_stalls;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int clamp_base(int v);
        if (v < int'(deg_lo))
            return int'(deg_lo);
        if (v > int'(deg_hi))
            return int'(deg_hi);
        return v;
    endfunction

    function automatic logic [1:0] dir_of(int v);
        if (v > 0)
            return DIR_UP;
        if (v < 0)
            return DIR_DOWN;
        return DIR_NONE;
    endfunction

    function automatic logic [11:0] pulse_for(int a);
        int span;
        int us;
        span = int'(deg_hi) - int'(deg_lo);
        us = int'(us_lo);
        if (span != 0)
            us += (a - int'(deg_lo)) * (int'(us_hi) - int'(us_lo)) / span;
        if (us < SAFE_LO)
            us = SAFE_LO;
        if (us > SAFE_HI)
            us = SAFE_HI;
        return us[11:0];
    endfunction

    function automatic void model_reset();
        lim_step   = 11'd50;
        pose_count = 7'd8;
        rev_band   = 11'd20;
        deg_lo     = 11'd0;
        deg_hi     = 11'd1800;
        us_lo      = 12'd500;
        us_hi      = 12'd2500;
        for (int i = 0; i < AXES; i++)
        begin
            axis_angle[i] = HOME_ANGLE;
            axis_dir[i]   = DIR_NONE;
        end
    endfunction

    function automatic void model_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_MAX_STEP:  lim_step   = val[10:0];
            REG_SUBSTEPS:  pose_count = val[6:0];
            REG_DEADBAND:  rev_band   = val[10:0];
            REG_DEG_MIN:   deg_lo     = val[10:0];
            REG_DEG_MAX:   deg_hi     = val[10:0];
            REG_US_AT_MIN: us_lo      = val;
            REG_US_AT_MAX: us_hi      = val;
            default: ;
        endcase
    endfunction

    // slew-limit the target, then queue the interpolated poses
    function automatic void predict_poses(target_t t);
        int     want   [AXES];
        int     origin [AXES];
        int     goal   [AXES];
        int     delta;
        int     mag;
        int     n;
        int     v;
        logic [1:0] d;
        pose_t  p;
        want[0] = int'(t.target_base);
        want[1] = int'(t.target_joint1);
        want[2] = int'(t.target_joint2);
        want[3] = int'(t.target_joint3);
        want[4] = int'(t.target_joint4);
        want[5] = int'(t.target_joint5);
        for (int i = 0; i < AXES; i++)
        begin
            origin[i] = axis_angle[i];
            delta = want[i] - axis_angle[i];
            d = dir_of(delta);
            mag = (delta < 0) ? -delta : delta;
            if (axis_dir[i] != DIR_NONE && d != DIR_NONE && d != axis_dir[i]
                && mag <= int'(rev_band))
            begin
                goal[i] = origin[i];
                continue;
            end
            if (delta > int'(lim_step))
                delta = int'(lim_step);
            if (delta < -int'(lim_step))
                delta = -int'(lim_step);
            v = origin[i] + delta;
            if (i == 0)
                goal[i] = clamp_base(v);
            else
                goal[i] = (v < 0) ? 0 : ((v > JOINT_MAX) ? JOINT_MAX : v);
            if (goal[i] != origin[i])
                axis_dir[i] = dir_of(goal[i] - origin[i]);
        end
        n = int'(pose_count);
        if (n < 1)
            n = 1;
        if (n > MAX_SUB)
            n = MAX_SUB;
        for (int s = 1; s <= n; s++)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                v = origin[i] + (goal[i] - origin[i]) * s / n;
                if (i == 0)
                    v = clamp_base(v);
                axis_angle[i] = v;
            end
            p.pose_base     = axis_angle[0][10:0];
            p.pose_joint1   = axis_angle[1][10:0];
            p.pose_joint2   = axis_angle[2][10:0];
            p.pose_joint3   = axis_angle[3][10:0];
            p.pose_joint4   = axis_angle[4][10:0];
            p.pose_joint5   = axis_angle[5][10:0];
            p.base_pulse_us = pulse_for(axis_angle[0]);
            p.last_substep  = (s == n);
            poses_due.push_back(p);
        end
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // pose checker
    initial
    begin
        pose_t e;
        pose_t a;
        forever
        begin
            @(posedge clk);
            if (pose.valid && pose.ready)
            begin
                a = pose.data;
                if (poses_due.size() == 0)
                begin
                    $display("%0t: unexpected pose word, expected none, actual %h", $time, a);
                    fail_count++;
                end
                else
                begin
                    e = poses_due.pop_front();
                    check_field("pose_base", int'(e.pose_base), int'(a.pose_base));
                    check_field("pose_joint1", int'(e.pose_joint1), int'(a.pose_joint1));
                    check_field("pose_joint2", int'(e.pose_joint2), int'(a.pose_joint2));
                    check_field("pose_joint3", int'(e.pose_joint3), int'(a.pose_joint3));
                    check_field("pose_joint4", int'(e.pose_joint4), int'(a.pose_joint4));
                    check_field("pose_joint5", int'(e.pose_joint5), int'(a.pose_joint5));
                    check_field("base_pulse_us", int'(e.base_pulse_us),
                                int'(a.base_pulse_us));
                    check_field("last_substep", int'(e.last_substep),
                                int'(a.last_substep));
                end
            end
        end
    end

    // receiver: random stalls, long ones now and then, forced hold-off
    initial
    begin
        pose.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold > 0)
            begin
                pose.ready <= 1'b0;
                ready_hold--;
            end
            else if (!ready_stalls)
                pose.ready <= 1'b1;
            else if ($urandom_range(0, 149) == 0)
            begin
                ready_hold = $urandom_range(20, 90);
                pose.ready <= 1'b0;
            end
            else
                pose.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    task automatic send_target(target_t t, int gap);
        if (gap > 0)
        begin
            tgt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tgt.valid <= 1'b1;
        tgt.data  <= t;
        @(posedge clk);
        while (!tgt.ready)
            @(posedge clk);
        predict_poses(t);
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    task automatic drain();
        tgt.valid <= 1'b0;
        @(posedge clk);
        while (poses_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        model_write(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic target_t all_axes(int v);
        target_t t;
        t = {AXES{v[10:0]}};
        return t;
    endfunction

    function automatic int near_angle(int c, int spread);
        int v;
        v = c + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > 2047)
            v = 2047;
        return v;
    endfunction

    function automatic target_t random_target(int spread);
        target_t t;
        int      v [AXES];
        for (int i = 0; i < AXES; i++)
            v[i] = ($urandom_range(0, 9) < 7) ? near_angle(axis_angle[i], spread)
                                             : $urandom_range(0, 2047);
        t.target_base   = v[0][10:0];
        t.target_joint1 = v[1][10:0];
        t.target_joint2 = v[2][10:0];
        t.target_joint3 = v[3][10:0];
        t.target_joint4 = v[4][10:0];
        t.target_joint5 = v[5][10:0];
        return t;
    endfunction

    task automatic test_default_moves();
        send_target(all_axes(2047), 0);
        send_target(all_axes(2047), 0);
        send_target(all_axes(990), 1);
        send_target(all_axes(1000), 0);
        send_target(all_axes(990), 0);
        send_target(all_axes(960), 2);
        send_target(all_axes(0), 0);
        send_target(all_axes(0), 0);
        send_target(all_axes(1800), 0);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_SUBSTEPS, 12'd0);
        write_reg(REG_MAX_STEP, 12'd1800);
        write_reg(REG_DEADBAND, 12'd0);
        send_target(all_axes(0), 0);
        send_target(all_axes(2047), 0);
        drain();
        write_reg(REG_SUBSTEPS, 12'd127);
        write_reg(REG_DEADBAND, 12'd1800);
        send_target(all_axes(100), 0);
        drain();
        write_reg(REG_SUBSTEPS, 12'd64);
        write_reg(REG_MAX_STEP, 12'd0);
        send_target(all_axes(1500), 0);
        drain();
        write_reg(REG_SUBSTEPS, 12'd1);
        write_reg(REG_MAX_STEP, 12'd700);
        write_reg(REG_UNUSED, 12'hfff);
        send_target(all_axes(1800), 0);
        drain();
    endtask

    task automatic test_base_range();
        // inverted range
        write_reg(REG_DEG_MIN, 12'd1200);
        write_reg(REG_DEG_MAX, 12'd600);
        write_reg(REG_SUBSTEPS, 12'd3);
        send_target(all_axes(0), 0);
        send_target(all_axes(2047), 0);
        drain();
        // equal ends, pulse below the safe window
        write_reg(REG_DEG_MIN, 12'd900);
        write_reg(REG_DEG_MAX, 12'd900);
        write_reg(REG_US_AT_MIN, 12'd0);
        send_target(all_axes(400), 0);
        drain();
        // falling map across the whole pulse range
        write_reg(REG_DEG_MIN, 12'd0);
        write_reg(REG_DEG_MAX, 12'd2047);
        write_reg(REG_US_AT_MIN, 12'd4095);
        write_reg(REG_US_AT_MAX, 12'd0);
        write_reg(REG_MAX_STEP, 12'd2047);
        send_target(all_axes(0), 0);
        send_target(all_axes(2047), 0);
        send_target(all_axes(1024), 0);
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++)
        begin
            ready_stalls = (ph != 3);
            write_reg(REG_MAX_STEP, (ph == 5) ? 12'hfff : 12'($urandom_range(0, 1800)));
            write_reg(REG_SUBSTEPS, (ph == 6) ? 12'd64 : 12'($urandom_range(1, 6)));
            write_reg(REG_DEADBAND, (ph == 5) ? 12'hfff : 12'($urandom_range(0, 120)));
            if (ph % 3 == 2)
            begin
                write_reg(REG_DEG_MIN, 12'($urandom_range(0, 2047)));
                write_reg(REG_DEG_MAX, 12'($urandom_range(0, 2047)));
            end
            else
            begin
                write_reg(REG_DEG_MIN, 12'($urandom_range(0, 700)));
                write_reg(REG_DEG_MAX, 12'($urandom_range(1100, 1800)));
            end
            write_reg(REG_US_AT_MIN, (ph == 4) ? 12'hfff : 12'($urandom_range(0, 1500)));
            write_reg(REG_US_AT_MAX, (ph == 4) ? 12'h000 : 12'($urandom_range(1500, 4095)));
            for (int k = 0; k < ((ph == 6) ? 4 : 28); k++)
                send_target(random_target(int'(lim_step) + int'(rev_band) + 10),
                            random_gap());
            drain();
        end
        ready_stalls = 1'b1;
    endtask

    task automatic test_backpressure();
        write_reg(REG_SUBSTEPS, 12'd8);
        write_reg(REG_MAX_STEP, 12'd300);
        ready_hold = 600;
        for (int k = 0; k < 6; k++)
            send_target(random_target(400), 0);
        drain();
    endtask

    initial
    begin
        fail_count   = 0;
        ready_hold   = 0;
        ready_stalls = 1'b1;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tgt.valid    = 1'b0;
        tgt.data     = '0;
        model_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_moves();
        test_register_extremes();
        test_base_range();
        test_backpressure();
        test_random_phases();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### servo_slew_limited_interpolator.f
src/ssli_pkg.sv
src/ssli_if.sv
src/ssli_lane.sv
src/servo_slew_limited_interpolator.sv
dv/tb_servo_slew_limited_interpolator.sv
